// ----- sv/ctm_pkg.sv -----
package ctm_pkg;

    localparam int BITMAP_WORDS = 32768;
    localparam int STACK_DEPTH  = 32;
    localparam int VALUE_BITS   = 40;

    localparam int WORD_BITS  = 32;
    localparam int BIT_AW     = 5;
    localparam int WIDX_BITS  = 15;
    localparam int CFG_AW     = 8;
    localparam int STEP_SHIFT = 2;

    localparam int BM_AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int STK_AW = $clog2(STACK_DEPTH);

    localparam longint HIGH_RESET = 64'd1048575;

    localparam logic [CFG_AW-1:0] CFG_RANGE_LOW  = 8'd0;
    localparam logic [CFG_AW-1:0] CFG_RANGE_HIGH = 8'd1;

    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef struct packed {
        t_cmd                  cmd;
        logic [VALUE_BITS-1:0] first_den;
        logic [VALUE_BITS-1:0] second_den;
        logic                  vary_second;
        logic [WIDX_BITS-1:0]  word_index;
    } t_in_beat;

    typedef struct packed {
        t_kind                done_kind;
        logic [WORD_BITS-1:0] word_data;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_SEED1,
        ST_MCALC,
        ST_MRD,
        ST_MWR,
        ST_STEP,
        ST_POP,
        ST_READ,
        ST_RDATA,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic cap_item;
        logic clr_wr;
        logic seed0;
        logic seed1;
        logic mark_calc;
        logic mark_wr;
        logic step;
        logic pop_load;
        logic rd_capture;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd item_cmd;
        logic seed_big;
        logic cut;
        logic pop_more;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/ctm_ram.sv -----
module ctm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ctm_ctrl.sv -----
module ctm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ctm_pkg::t_cmd    i_in_cmd,
    input  ctm_pkg::t_dp_sts i_sts,
    output logic             o_busy,
    output ctm_pkg::t_dp_cmd o_cmd
);

    ctm_pkg::t_state r_state;
    ctm_pkg::t_state n_state;
    logic            accept;

    assign accept = i_in_valid && (r_state == ctm_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctm_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ctm_pkg::ST_IDLE;
                end
            end
            ctm_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_cmd)
                        ctm_pkg::CMD_SEARCH: n_state = ctm_pkg::ST_SEED;
                        ctm_pkg::CMD_MARK:   n_state = ctm_pkg::ST_MCALC;
                        ctm_pkg::CMD_READ:   n_state = ctm_pkg::ST_READ;
                        ctm_pkg::CMD_NONE:   n_state = ctm_pkg::ST_IDLE;
                    endcase
                end
            end
            ctm_pkg::ST_SEED: begin
                n_state = i_sts.seed_big ? ctm_pkg::ST_FIN : ctm_pkg::ST_SEED1;
            end
            ctm_pkg::ST_SEED1: n_state = ctm_pkg::ST_MCALC;
            ctm_pkg::ST_MCALC: n_state = ctm_pkg::ST_MRD;
            ctm_pkg::ST_MRD:   n_state = ctm_pkg::ST_MWR;
            ctm_pkg::ST_MWR: begin
                n_state = (i_sts.item_cmd == ctm_pkg::CMD_MARK) ? ctm_pkg::ST_FIN
                                                                : ctm_pkg::ST_STEP;
            end
            ctm_pkg::ST_STEP: begin
                if (!i_sts.cut) begin
                    n_state = ctm_pkg::ST_MCALC;
                end else if (i_sts.pop_more) begin
                    n_state = ctm_pkg::ST_POP;
                end else begin
                    n_state = ctm_pkg::ST_FIN;
                end
            end
            ctm_pkg::ST_POP:   n_state = ctm_pkg::ST_STEP;
            ctm_pkg::ST_READ:  n_state = ctm_pkg::ST_RDATA;
            ctm_pkg::ST_RDATA: n_state = ctm_pkg::ST_FIN;
            ctm_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ctm_pkg::ST_IDLE;
                end
            end
            default: n_state = ctm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ctm_pkg::ST_IDLE);
        unique case (r_state)
            ctm_pkg::ST_CLEAR: o_cmd.clr_wr     = 1'b1;
            ctm_pkg::ST_IDLE:  o_cmd.cap_item   = accept;
            ctm_pkg::ST_SEED:  o_cmd.seed0      = !i_sts.seed_big;
            ctm_pkg::ST_SEED1: o_cmd.seed1      = 1'b1;
            ctm_pkg::ST_MCALC: o_cmd.mark_calc  = 1'b1;
            ctm_pkg::ST_MRD:   o_cmd            = '0;
            ctm_pkg::ST_MWR:   o_cmd.mark_wr    = 1'b1;
            ctm_pkg::ST_STEP:  o_cmd.step       = 1'b1;
            ctm_pkg::ST_POP:   o_cmd.pop_load   = 1'b1;
            ctm_pkg::ST_READ:  o_cmd            = '0;
            ctm_pkg::ST_RDATA: o_cmd.rd_capture = 1'b1;
            ctm_pkg::ST_FIN:   o_cmd.out_load   = i_sts.out_free;
            default:           o_cmd            = '0;
        endcase
    end

endmodule

// ----- sv/ctm_dp.sv -----
module ctm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ctm_pkg::t_dp_cmd                  i_cmd,
    output ctm_pkg::t_dp_sts                  o_sts,
    input  ctm_pkg::t_in_beat                 i_in_beat,
    input  logic                              i_cfg_we,
    input  logic [ctm_pkg::CFG_AW-1:0]        i_cfg_index,
    input  logic [ctm_pkg::VALUE_BITS-1:0]    i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output ctm_pkg::t_out_beat                o_out_beat
);

    localparam int VB = ctm_pkg::VALUE_BITS;
    localparam int NB = ctm_pkg::VALUE_BITS + 3;

    // range registers
    logic [VB-1:0] r_lo;
    logic [VB-1:0] r_hi;

    // captured item
    ctm_pkg::t_cmd                 r_cmd;
    logic [VB-1:0]                 r_a;
    logic [VB-1:0]                 r_mv;
    logic                          r_vary;
    logic [ctm_pkg::WIDX_BITS-1:0] r_widx;

    // walk state
    logic [VB-1:0]              r_cur;
    logic [VB-1:0]              r_prev;
    logic [ctm_pkg::STK_AW-1:0] r_lvl;

    // mark unit
    logic [ctm_pkg::BM_AW-1:0]  r_maddr;
    logic [ctm_pkg::BIT_AW-1:0] r_mbit;
    logic                       r_mok;

    logic [ctm_pkg::BM_AW-1:0]     r_clr;
    logic [ctm_pkg::WORD_BITS-1:0] r_rd_word;

    logic               r_out_valid;
    ctm_pkg::t_out_beat r_out_beat;

    logic [NB-1:0]              inc;
    logic [NB-1:0]              nv;
    logic                       cut;
    logic                       full;
    logic [ctm_pkg::STK_AW-1:0] lvl_dn;
    logic                       pop_more;

    logic [VB-1:0] off;
    logic [63:0]   word64;
    logic          mark_ok;

    logic [31:0]               widx32;
    logic                      rd_ok;
    logic [ctm_pkg::BM_AW-1:0] widx_addr;

    logic                          bm_we;
    logic [ctm_pkg::BM_AW-1:0]     bm_waddr;
    logic [ctm_pkg::WORD_BITS-1:0] bm_wdata;
    logic [ctm_pkg::BM_AW-1:0]     bm_raddr;
    logic [ctm_pkg::WORD_BITS-1:0] bm_rdata;

    logic                       stk_we;
    logic [ctm_pkg::STK_AW-1:0] stk_waddr;
    logic [VB-1:0]              stk_wdata;
    logic [ctm_pkg::STK_AW-1:0] stk_raddr;
    logic [VB-1:0]              stk_rdata;

    logic out_free;

    assign inc      = {1'b0, r_prev, 2'b00};
    assign nv       = {3'b000, r_cur} + inc;
    assign cut      = (r_prev == '0) || (nv > {3'b000, r_hi});
    assign full     = (r_lvl == ctm_pkg::STK_AW'(ctm_pkg::STACK_DEPTH - 1));
    assign lvl_dn   = r_lvl - ctm_pkg::STK_AW'(1);
    assign pop_more = r_vary ? (lvl_dn != '0) : (lvl_dn > ctm_pkg::STK_AW'(1));

    assign off     = r_mv - r_lo;
    assign word64  = 64'(off >> ctm_pkg::BIT_AW);
    assign mark_ok = (r_mv >= r_lo) && (r_mv <= r_hi)
                     && (word64 < 64'(ctm_pkg::BITMAP_WORDS));

    assign widx32    = 32'(r_widx);
    assign rd_ok     = widx32 < 32'(ctm_pkg::BITMAP_WORDS);
    assign widx_addr = widx32[ctm_pkg::BM_AW-1:0];

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = r_maddr;
        bm_wdata = bm_rdata | (ctm_pkg::WORD_BITS'(1) << r_mbit);
        if (i_cmd.clr_wr) begin
            bm_we    = 1'b1;
            bm_waddr = r_clr;
            bm_wdata = '0;
        end else if (i_cmd.mark_wr) begin
            bm_we = r_mok;
        end
    end

    assign bm_raddr = (r_cmd == ctm_pkg::CMD_READ) ? widx_addr : r_maddr;

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_lvl;
        stk_wdata = nv[VB-1:0];
        if (i_cmd.seed0) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = r_a;
        end else if (i_cmd.seed1) begin
            stk_we    = 1'b1;
            stk_waddr = ctm_pkg::STK_AW'(1);
            stk_wdata = r_mv;
        end else if (i_cmd.step) begin
            stk_we = !cut && !full;
        end
    end

    assign stk_raddr = r_lvl - ctm_pkg::STK_AW'(2);

    ctm_ram #(
        .WIDTH (ctm_pkg::WORD_BITS),
        .DEPTH (ctm_pkg::BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    ctm_ram #(
        .WIDTH (ctm_pkg::VALUE_BITS),
        .DEPTH (ctm_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= '0;
            r_hi        <= VB'(ctm_pkg::HIGH_RESET);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cmd       <= ctm_pkg::CMD_NONE;
            r_lvl       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ctm_pkg::CFG_RANGE_LOW) begin
                    r_lo <= i_cfg_data;
                end else if (i_cfg_index == ctm_pkg::CFG_RANGE_HIGH) begin
                    r_hi <= i_cfg_data;
                end
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + ctm_pkg::BM_AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.cap_item) begin
                r_cmd <= i_in_beat.cmd;
            end
            if (i_cmd.seed1) begin
                r_lvl <= ctm_pkg::STK_AW'(2);
            end else if (i_cmd.step) begin
                if (cut) begin
                    r_lvl <= lvl_dn;
                end else if (!full) begin
                    r_lvl <= r_lvl + ctm_pkg::STK_AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_a    <= i_in_beat.first_den;
            r_mv   <= i_in_beat.second_den;
            r_vary <= i_in_beat.vary_second;
            r_widx <= i_in_beat.word_index;
        end
        if (i_cmd.seed1) begin
            r_cur  <= r_a;
            r_prev <= r_mv;
        end else if (i_cmd.step) begin
            if (cut) begin
                r_cur <= r_prev;
            end else begin
                r_mv <= nv[VB-1:0];
                if (full) begin
                    r_cur <= nv[VB-1:0];
                end else begin
                    r_cur  <= r_prev;
                    r_prev <= nv[VB-1:0];
                end
            end
        end else if (i_cmd.pop_load) begin
            r_prev <= stk_rdata;
        end
        if (i_cmd.mark_calc) begin
            r_maddr <= word64[ctm_pkg::BM_AW-1:0];
            r_mbit  <= off[ctm_pkg::BIT_AW-1:0];
            r_mok   <= mark_ok;
        end
        if (i_cmd.rd_capture) begin
            r_rd_word <= rd_ok ? bm_rdata : '0;
        end
        if (i_cmd.out_load) begin
            unique case (r_cmd)
                ctm_pkg::CMD_SEARCH: begin
                    r_out_beat.done_kind <= ctm_pkg::KIND_SEARCH;
                    r_out_beat.word_data <= '0;
                end
                ctm_pkg::CMD_MARK: begin
                    r_out_beat.done_kind <= ctm_pkg::KIND_MARK;
                    r_out_beat.word_data <= '0;
                end
                ctm_pkg::CMD_READ: begin
                    r_out_beat.done_kind <= ctm_pkg::KIND_READ;
                    r_out_beat.word_data <= r_rd_word;
                end
                ctm_pkg::CMD_NONE: begin
                    r_out_beat.done_kind <= ctm_pkg::KIND_SEARCH;
                    r_out_beat.word_data <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.item_cmd = r_cmd;
        o_sts.seed_big = r_mv > r_hi;
        o_sts.cut      = cut;
        o_sts.pop_more = pop_more;
        o_sts.clr_last = (r_clr == ctm_pkg::BM_AW'(ctm_pkg::BITMAP_WORDS - 1));
        o_sts.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- sv/continuant_tree_marker.sv -----
// channel  direction  signals
// in       input      i_in_valid, o_in_stall, i_in_beat
// out      output     o_out_valid, i_out_stall, o_out_beat
// cfg      input      i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// one item at a time; a mark computes the bitmap address, reads the word and
// writes it back with the bit set, a read fetches one bitmap word, and a search
// seeds the stack, then marks and steps node by node, popping the stack on a cut
// after reset the bitmap is swept to zero, one word a cycle
// a finished beat waits in the output register; the next item is taken meanwhile
// and its own result waits for that register to free up
module continuant_tree_marker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ctm_pkg::t_in_beat                 i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ctm_pkg::t_out_beat                o_out_beat,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ctm_pkg::CFG_AW-1:0]        i_cfg_index,
    input  logic [ctm_pkg::VALUE_BITS-1:0]    i_cfg_data
);

    ctm_pkg::t_dp_cmd dp_cmd;
    ctm_pkg::t_dp_sts dp_sts;
    logic             busy;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;

    ctm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_beat.cmd),
        .i_sts      (dp_sts),
        .o_busy     (busy),
        .o_cmd      (dp_cmd)
    );

    ctm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- test/testbench.sv -----
module testbench;

    import ctm_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] BIT38     = 40'h40_0000_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_beat = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_AW-1:0]     i_cfg_index = '0;
    logic [VALUE_BITS-1:0] i_cfg_data = '0;

    continuant_tree_marker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predicted block state
    logic [WORD_BITS-1:0]  presence [BITMAP_WORDS];
    logic [VALUE_BITS-1:0] range_lo = '0;
    logic [VALUE_BITS-1:0] range_hi = HIGH_RESET[VALUE_BITS-1:0];

    t_out_beat awaited_done[$];

    int  errors = 0;
    int  n_search = 0;
    int  n_mark = 0;
    int  n_read = 0;
    int  n_cfg = 0;
    int  walk_steps = 0;
    int  hold_left = 0;
    bit  no_gaps = 1'b0;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        return VALUE_BITS'({$urandom(), $urandom()});
    endfunction

    function automatic void set_presence(logic [63:0] v);
        logic [63:0] off;
        if (v < 64'(range_lo) || v > 64'(range_hi))
            return;
        off = v - 64'(range_lo);
        if ((off >> BIT_AW) >= 64'(BITMAP_WORDS))
            return;
        presence[off[BIT_AW+BM_AW-1:BIT_AW]][off[BIT_AW-1:0]] = 1'b1;
    endfunction

    function automatic void walk_tree(logic [VALUE_BITS-1:0] a, logic [VALUE_BITS-1:0] b,
                                      logic vary);
        logic [63:0] dens [STACK_DEPTH];
        logic [63:0] inc;
        logic [63:0] nv;
        int          lvl;
        int          base;
        if (b > range_hi)
            return;
        set_presence(64'(b));
        dens[0] = 64'(a);
        dens[1] = 64'(b);
        dens[2] = 64'(a);
        lvl = 2;
        base = vary ? 0 : 1;
        while (lvl > base) begin
            inc = dens[lvl-1] << STEP_SHIFT;
            nv = dens[lvl] + inc;
            if (inc == '0 || nv > 64'(range_hi)) begin
                lvl--;
            end else begin
                set_presence(nv);
                dens[lvl] = nv;
                walk_steps++;
                if (lvl + 1 < STACK_DEPTH) begin
                    lvl++;
                    dens[lvl] = dens[lvl-2];
                end
            end
        end
    endfunction

    function automatic void predict_done(t_in_beat item);
        t_out_beat want;
        want = '0;
        case (item.cmd)
            CMD_SEARCH: begin
                walk_tree(item.first_den, item.second_den, item.vary_second);
                want.done_kind = KIND_SEARCH;
                awaited_done.push_back(want);
                n_search++;
            end
            CMD_MARK: begin
                set_presence(64'(item.second_den));
                want.done_kind = KIND_MARK;
                awaited_done.push_back(want);
                n_mark++;
            end
            CMD_READ: begin
                want.done_kind = KIND_READ;
                if (int'(item.word_index) < BITMAP_WORDS)
                    want.word_data = presence[item.word_index];
                awaited_done.push_back(want);
                n_read++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_beat make_item(t_cmd c, logic [VALUE_BITS-1:0] a,
                                           logic [VALUE_BITS-1:0] b, logic v,
                                           logic [WIDX_BITS-1:0] w);
        t_in_beat item;
        item.cmd = c;
        item.first_den = a;
        item.second_den = b;
        item.vary_second = v;
        item.word_index = w;
        return item;
    endfunction

    task automatic send_item(input t_in_beat item);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_done(item);
    endtask

    task automatic set_range(input logic [VALUE_BITS-1:0] lo, input logic [VALUE_BITS-1:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_RANGE_LOW;
        i_cfg_data <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_RANGE_HIGH;
        i_cfg_data <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        range_lo = lo;
        range_hi = hi;
        n_cfg++;
    endtask

    // wait for every result, then let an unanswered item finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_done.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver stalls: after each beat, and now and then on its own
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            hold_left = draw_gap();
        else if (hold_left == 0 && $urandom_range(0, 15) == 0)
            hold_left = draw_gap();
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_done.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat kind %0d data %h", $time,
                         o_out_beat.done_kind, o_out_beat.word_data);
            end else begin
                want = awaited_done.pop_front();
                if (o_out_beat.done_kind !== want.done_kind) begin
                    errors++;
                    $display("%0t: done_kind expected %0d got %0d", $time,
                             want.done_kind, o_out_beat.done_kind);
                end
                if (o_out_beat.word_data !== want.word_data) begin
                    errors++;
                    $display("%0t: word_data expected %h got %h", $time,
                             want.word_data, o_out_beat.word_data);
                end
            end
        end
    end

    task automatic test_after_reset();
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '0));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '1));
        send_item(make_item(CMD_MARK, '0, 40'd0, 1'b0, '0));
        send_item(make_item(CMD_MARK, '0, 40'd1048575, 1'b0, '0));
        send_item(make_item(CMD_MARK, '0, 40'd1048576, 1'b0, '0));
        send_item(make_item(CMD_NONE, VALUE_MAX, VALUE_MAX, 1'b1, '1));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '0));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '1));
        settle();
    endtask

    task automatic test_small_range();
        set_range(40'd100, 40'd300);
        send_item(make_item(CMD_MARK, '0, 40'd99, 1'b0, '0));
        send_item(make_item(CMD_MARK, '0, 40'd300, 1'b0, '0));
        // seed above the range
        send_item(make_item(CMD_SEARCH, 40'd1, 40'd301, 1'b0, '0));
        send_item(make_item(CMD_SEARCH, 40'd1, 40'd2, 1'b0, '0));
        // zero second seed, level one grows
        send_item(make_item(CMD_SEARCH, 40'd3, 40'd0, 1'b1, '0));
        send_item(make_item(CMD_SEARCH, 40'd0, 40'd0, 1'b1, '0));
        for (int w = 0; w < 4; w++)
            send_item(make_item(CMD_READ, '0, '0, 1'b0, w[WIDX_BITS-1:0]));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, 15'd6));
        settle();
    endtask

    task automatic test_extremes();
        set_range('0, VALUE_MAX);
        send_item(make_item(CMD_MARK, '0, 40'd1 << 20, 1'b0, '0));
        send_item(make_item(CMD_SEARCH, VALUE_MAX, VALUE_MAX, 1'b1, '0));
        send_item(make_item(CMD_SEARCH, BIT38, BIT38, 1'b0, '0));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '1));
        settle();
        set_range(VALUE_MAX, VALUE_MAX);
        send_item(make_item(CMD_MARK, '0, VALUE_MAX, 1'b0, '0));
        send_item(make_item(CMD_READ, '0, '0, 1'b0, '0));
        settle();
        set_range(40'd5, '0);
        send_item(make_item(CMD_SEARCH, '0, '0, 1'b1, '0));
        settle();
    endtask

    // phases of random items; most keep the range small so walks stay short
    task automatic test_random();
        t_in_beat item;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        int pick;
        int span;
        bit wide;
        for (int phase = 0; phase < 6; phase++) begin
            wide = (phase == 4);
            no_gaps = (phase % 3 == 1);
            if (wide) begin
                lo = ($urandom_range(0, 1) == 0) ? '0 : rand_value();
                hi = VALUE_MAX;
            end else begin
                hi = VALUE_BITS'($urandom_range(16, 500));
                lo = ($urandom_range(0, 3) == 0) ? '0
                                                 : VALUE_BITS'($urandom_range(0, int'(hi)));
            end
            set_range(lo, hi);
            span = wide ? 0 : int'(hi - lo) / WORD_BITS + 1;
            for (int i = 0; i < 19; i++) begin
                item.first_den = rand_value();
                item.second_den = rand_value();
                item.vary_second = 1'($urandom_range(0, 1));
                item.word_index = WIDX_BITS'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    item.cmd = CMD_SEARCH;
                    if (wide) begin
                        item.first_den = item.first_den | BIT38;
                        item.second_den = item.second_den | BIT38;
                    end else begin
                        if ($urandom_range(0, 4) != 0)
                            item.first_den = VALUE_BITS'($urandom_range(0, int'(hi)));
                        if ($urandom_range(0, 7) != 0)
                            item.second_den = VALUE_BITS'($urandom_range(0, int'(hi) + 8));
                    end
                end else if (pick < 70) begin
                    item.cmd = CMD_MARK;
                    if ($urandom_range(0, 5) != 0)
                        item.second_den = wide
                            ? lo + VALUE_BITS'($urandom_range(0, 1 << 21))
                            : VALUE_BITS'($urandom_range(0, int'(hi) + 8));
                end else if (pick < 95) begin
                    item.cmd = CMD_READ;
                    if (!wide && $urandom_range(0, 5) != 0)
                        item.word_index = WIDX_BITS'($urandom_range(0, span));
                end else begin
                    item.cmd = CMD_NONE;
                end
                send_item(item);
            end
            settle();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        foreach (presence[i])
            presence[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_small_range();
        test_extremes();
        test_random();
        $display("covered %0d searches (%0d tree steps), %0d marks, %0d reads", n_search,
                 walk_steps, n_mark, n_read);
        $display("over %0d range settings with random gaps and stalls", n_cfg);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #200000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- continuant_tree_marker.f -----
sv/ctm_pkg.sv
sv/ctm_ram.sv
sv/ctm_ctrl.sv
sv/ctm_dp.sv
sv/continuant_tree_marker.sv
test/testbench.sv
